>>> rtl/heu_pkg.sv
// types, constants and character tables of the html entity decoder
package heu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_HASH = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam int NAMED_COUNT = 7;
  localparam int NAME_MAX    = 4;

  typedef struct packed {
    logic [1:0]             mode;
    logic [7:0]             value;
    logic [NAMED_COUNT-1:0] alive;
  } match_t;

  typedef struct packed {
    logic       emit;
    logic       tail;
    logic [7:0] tail_byte;
    logic       last;
  } job_t;

  localparam match_t MATCH_IDLE = '{mode: MODE_NONE, value: 8'd0, alive: 7'h7f};

  localparam logic [7:0] VALUE_CAP = 8'd128;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;

  // lt gt amp quot #39 apos nbsp, lower case
  localparam logic [7:0] NAMED_STR [NAMED_COUNT][NAME_MAX] = '{
    '{8'h6c, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h61, 8'h6d, 8'h70, 8'h00},
    '{8'h71, 8'h75, 8'h6f, 8'h74},
    '{8'h23, 8'h33, 8'h39, 8'h00},
    '{8'h61, 8'h70, 8'h6f, 8'h73},
    '{8'h6e, 8'h62, 8'h73, 8'h70}
  };
  localparam logic [2:0] NAMED_LEN [NAMED_COUNT] = '{
    3'd2, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4
  };
  localparam logic [7:0] NAMED_OUT [NAMED_COUNT] = '{
    8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27, 8'h27, 8'h20
  };

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) r = b + 8'd32;
    return r;
  endfunction

  function automatic logic is_dec(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39);
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

>>> rtl/heu_step.sv
// next-state and result job logic for one input byte
module heu_step #(
  parameter int MAX_ENTITY_LEN = 12,
  localparam int IDX_W = $clog2(MAX_ENTITY_LEN)
) (
  input  heu_pkg::item_t  item_i,
  input  logic [IDX_W-1:0] cnt_i,
  input  heu_pkg::match_t match_i,
  output logic [IDX_W-1:0] cnt_o,
  output heu_pkg::match_t match_o,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_idx_o,
  output logic [7:0]       wr_data_o,
  output logic [IDX_W-1:0] rel_o,
  output heu_pkg::job_t   job_o
);
  import heu_pkg::*;

  logic [7:0]             b;
  logic [7:0]             lb;
  logic [IDX_W-1:0]       pos;
  logic                   pos_short;
  logic [NAMED_COUNT-1:0] mask_n;
  logic                   named_hit;
  logic [7:0]             named_byte;
  logic                   num_hit;
  logic [1:0]             mode_n;
  logic [11:0]            base;
  logic [11:0]            val_w;
  logic [7:0]             val_n;
  logic [4:0]             hx;
  logic                   extend;

  assign b         = item_i.in_byte;
  assign lb        = fold(b);
  assign pos       = cnt_i - IDX_W'(1);
  assign pos_short = (pos < IDX_W'(NAME_MAX));
  assign base      = {4'd0, match_i.value};
  assign hx        = hex_val(b);

  // named references: surviving candidates and a hit on the semicolon
  always_comb begin
    mask_n     = '0;
    named_hit  = 1'b0;
    named_byte = 8'd0;
    for (int k = 0; k < NAMED_COUNT; k++) begin
      if (match_i.alive[k] && pos_short && (pos[2:0] < NAMED_LEN[k]) &&
          (lb == NAMED_STR[k][pos[1:0]])) begin
        mask_n[k] = 1'b1;
      end
    end
    for (int k = NAMED_COUNT - 1; k >= 0; k--) begin
      if (match_i.alive[k] && (pos == IDX_W'(NAMED_LEN[k]))) begin
        named_hit  = 1'b1;
        named_byte = NAMED_OUT[k];
      end
    end
  end

  assign num_hit = ((match_i.mode == MODE_DEC) ||
                    ((match_i.mode == MODE_HEX) && (cnt_i > IDX_W'(3)))) &&
                   (match_i.value != 8'd0) && !match_i.value[7];

  // numeric references
  always_comb begin
    mode_n = MODE_NONE;
    val_w  = base;
    if (cnt_i == IDX_W'(1)) begin
      if (b == CH_HASH) mode_n = MODE_HASH;
    end else begin
      case (match_i.mode)
        MODE_HASH: begin
          if (b == CH_X_LO || b == CH_X_UP) begin
            mode_n = MODE_HEX;
          end else if (is_dec(b)) begin
            mode_n = MODE_DEC;
            val_w  = 12'(b - 8'h30);
          end
        end
        MODE_DEC: begin
          if (is_dec(b)) begin
            mode_n = MODE_DEC;
            val_w  = base * 12'd10 + 12'(b - 8'h30);
          end
        end
        MODE_HEX: begin
          if (hx[4]) begin
            mode_n = MODE_HEX;
            val_w  = (base << 4) + 12'(hx[3:0]);
          end
        end
        default: mode_n = MODE_NONE;
      endcase
    end
    val_n = (val_w > 12'(VALUE_CAP)) ? VALUE_CAP : val_w[7:0];
  end

  assign extend = ((mask_n != '0) || (mode_n != MODE_NONE)) &&
                  (cnt_i < IDX_W'(MAX_ENTITY_LEN - 1));

  always_comb begin
    cnt_o     = cnt_i;
    match_o   = match_i;
    wr_en_o   = 1'b0;
    wr_idx_o  = cnt_i;
    wr_data_o = b;
    rel_o     = '0;
    job_o     = '{emit: 1'b0, tail: 1'b0, tail_byte: b, last: item_i.in_last};
    if (cnt_i == '0) begin
      if (b == CH_AMP) begin
        cnt_o    = IDX_W'(1);
        match_o  = MATCH_IDLE;
        wr_en_o  = 1'b1;
        wr_idx_o = '0;
      end else begin
        job_o.tail = 1'b1;
      end
    end else if (b == CH_SEMI) begin
      cnt_o      = '0;
      match_o    = MATCH_IDLE;
      job_o.tail = 1'b1;
      if (named_hit) begin
        job_o.tail_byte = named_byte;
      end else if (num_hit) begin
        job_o.tail_byte = match_i.value;
      end else begin
        rel_o = cnt_i;
      end
    end else if (b == CH_AMP) begin
      rel_o    = cnt_i;
      cnt_o    = IDX_W'(1);
      match_o  = MATCH_IDLE;
      wr_en_o  = 1'b1;
      wr_idx_o = '0;
    end else if (extend) begin
      wr_en_o = 1'b1;
      cnt_o   = cnt_i + IDX_W'(1);
      match_o = '{mode: mode_n, value: val_n, alive: mask_n};
    end else begin
      rel_o      = cnt_i;
      job_o.tail = 1'b1;
      cnt_o      = '0;
      match_o    = MATCH_IDLE;
    end
    // end of stream flushes whatever is still held, this byte last
    if (item_i.in_last && (cnt_o != '0)) begin
      rel_o           = cnt_i;
      job_o.tail      = 1'b1;
      job_o.tail_byte = b;
      cnt_o           = '0;
      match_o         = MATCH_IDLE;
    end
    job_o.emit = job_o.tail || (rel_o != '0);
  end

endmodule

>>> rtl/html_entity_unescape_top.sv
// top level of the streaming html entity decoder
// the first result byte of a transfer is presented in the cycle after it is taken in
//   while the output register is free; a transfer parked behind a busy job waits for it
// throughput: one byte per cycle in and out while out_stall_i is low; a release of n held
//   bytes is played out with any tail byte, one byte per cycle; one transfer parks, then input stalls
// reset: control state, counters and handshakes clear at once; held bytes are undefined
module html_entity_unescape_top #(
  parameter int MAX_ENTITY_LEN = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  heu_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output heu_pkg::result_t out_item_o
);
  import heu_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTITY_LEN);
  localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 1);

  // decoder state
  logic [IDX_W-1:0] cnt_q, cnt_d;
  match_t           match_q, match_d;
  logic [7:0]       pend_q [MAX_ENTITY_LEN];

  // skid stage on the input side
  logic  skid_valid_q, skid_valid_d;
  item_t skid_q, skid_d;

  // result job being played out: held bytes first, then the tail byte
  logic             job_valid_q, job_valid_d;
  logic [IDX_W-1:0] rel_q, rel_d;
  logic [CNT_W-1:0] tot_q, tot_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [7:0]       tail_q, tail_d;
  logic             last_q, last_d;

  item_t            cur_item;
  logic             cur_valid;
  logic             out_final;
  logic             job_done;
  logic             can_load;
  logic             proc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] rel_n;
  job_t             job_n;

  // a parked item goes ahead of anything new on the port
  assign cur_item  = skid_valid_q ? skid_q : in_item_i;
  assign cur_valid = skid_valid_q || in_valid_i;

  // the output register frees up on the transfer of a job's final byte
  assign out_final = (ptr_q == tot_q - CNT_W'(1));
  assign job_done  = job_valid_q && !out_stall_i && out_final;
  assign can_load  = !job_valid_q || job_done;
  assign proc      = cur_valid && can_load;

  // stall comes from a register only, so the two sides stay apart
  assign in_stall_o = skid_valid_q;

  heu_step #(
    .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
  ) u_step (
    .item_i   (cur_item),
    .cnt_i    (cnt_q),
    .match_i  (match_q),
    .cnt_o    (cnt_d),
    .match_o  (match_d),
    .wr_en_o  (wr_en),
    .wr_idx_o (wr_idx),
    .wr_data_o(wr_data),
    .rel_o    (rel_n),
    .job_o    (job_n)
  );

  // skid and job sequencing
  always_comb begin
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (can_load) skid_valid_d = 1'b0;
    end else if (in_valid_i && !can_load) begin
      skid_valid_d = 1'b1;
      skid_d       = in_item_i;
    end

    job_valid_d = job_valid_q;
    rel_d       = rel_q;
    tot_d       = tot_q;
    ptr_d       = ptr_q;
    tail_d      = tail_q;
    last_d      = last_q;
    if (proc && job_n.emit) begin
      job_valid_d = 1'b1;
      rel_d       = rel_n;
      tot_d       = CNT_W'(rel_n) + CNT_W'(job_n.tail);
      ptr_d       = '0;
      tail_d      = job_n.tail_byte;
      last_d      = job_n.last;
    end else if (job_done) begin
      job_valid_d = 1'b0;
    end else if (job_valid_q && !out_stall_i) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      match_q      <= MATCH_IDLE;
      skid_valid_q <= 1'b0;
      job_valid_q  <= 1'b0;
      tot_q        <= CNT_W'(1);
      ptr_q        <= '0;
    end else begin
      if (proc) begin
        cnt_q   <= cnt_d;
        match_q <= match_d;
      end
      skid_valid_q <= skid_valid_d;
      job_valid_q  <= job_valid_d;
      tot_q        <= tot_d;
      ptr_q        <= ptr_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
    rel_q  <= rel_d;
    tail_q <= tail_d;
    last_q <= last_d;
    if (proc && wr_en) pend_q[wr_idx] <= wr_data;
  end

  // held bytes are read straight from the buffer: nothing is written while a job plays out
  assign out_valid_o         = job_valid_q;
  assign out_item_o.out_byte = (ptr_q < CNT_W'(rel_q)) ? pend_q[ptr_q[IDX_W-1:0]] : tail_q;
  assign out_item_o.out_last = last_q && out_final;

  // the end of the stream always leaves the decoder idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_last |-> cnt_q == '0)
    else $error("stream end with bytes still held");

  // an item only parks while the output register is busy
  a_skid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> job_valid_q)
    else $error("skid stage full with no job in flight");

  // the play-out pointer stays within the job
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (tot_q != '0) && (ptr_q < tot_q))
    else $error("job pointer out of range");

  // a numeric match can only be under way while an ampersand is held
  a_mode_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q.mode != MODE_NONE |-> cnt_q != '0)
    else $error("numeric mode with empty buffer");

endmodule
